/* sv/hkrt_pkg.sv */
// Shared types, codes and constants of the HID keyboard report tracker.
package hkrt_pkg;

  // Report geometry.
  localparam int KEY_SLOTS      = 6;
  localparam int NKRO_MAX_USAGE = 255;
  localparam int STORE_DEPTH    = 32;
  localparam int STORE_AW       = 5;
  localparam int NKRO_BYTES     = (NKRO_MAX_USAGE / 8) + 1;
  localparam int SLOT_W         = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int READ_W         = 6;
  localparam int READ_LEN_SLOT  = 2 + KEY_SLOTS;
  localparam int READ_LEN_NKRO  = 2 + NKRO_BYTES;

  // Action codes.
  localparam logic [2:0] ACT_PRESS   = 3'd0;
  localparam logic [2:0] ACT_RELEASE = 3'd1;
  localparam logic [2:0] ACT_QUERY   = 3'd2;
  localparam logic [2:0] ACT_CLEAR   = 3'd3;
  localparam logic [2:0] ACT_READ    = 3'd4;

  // Status codes.
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STS_RANGE     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NKRO_MODE     = 2'd0;
  localparam logic [1:0] CFG_IMPLICIT_MODS = 2'd1;
  localparam logic [1:0] CFG_MASKED_MODS   = 2'd2;
  localparam logic [1:0] CFG_GUI_LOCK      = 2'd3;

  // Modifier usages and the two GUI modifier positions.
  localparam logic [7:0] MOD_FIRST = 8'hE0;
  localparam logic [7:0] MOD_LAST  = 8'hE7;
  localparam logic [2:0] MOD_LGUI  = 3'd3;
  localparam logic [2:0] MOD_RGUI  = 3'd7;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT,
    ST_READ
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_step;
    logic emit;
    logic read_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic is_read;
    logic is_slot_key;
    logic scan_done;
    logic read_last;
  } sts_t;

  // Reported modifier byte from held bits and the two mask registers.
  function automatic logic [7:0] compose_mods(input logic [7:0] held,
                                              input logic [7:0] masked,
                                              input logic [7:0] implicit);
    return (held & ~masked) | implicit;
  endfunction

endpackage

/* sv/hkrt_ctrl.sv */
// Sequencing state machine of the HID keyboard report tracker.
module hkrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  hkrt_pkg::sts_t sts,
  output hkrt_pkg::cmd_t cmd
);
  import hkrt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_read) begin
          state_nxt = ST_READ;
        end else if (sts.is_slot_key) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.out_free) begin
          cmd.read_step = 1'b1;
          if (sts.read_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // An accepted transfer always starts execution on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted item did not enter execution");

  // The final byte of a report read returns the controller to idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && sts.out_free && sts.read_last) |=> (state_r == ST_IDLE))
    else $error("report read did not end after its last byte");

  // A slot scan never emits results by itself.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (!cmd.emit && !cmd.read_step))
    else $error("result loaded during slot scan");
`endif

endmodule

/* sv/hkrt_dp.sv */
// Datapath of the HID keyboard report tracker: registers, key store and output stage.
module hkrt_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic [2:0]     in_action,
  input  logic [7:0]     in_usage,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_data,
  output logic           out_last,
  output logic           out_mods_changed,
  output logic           out_pressed,
  output logic [1:0]     out_status,
  input  hkrt_pkg::cmd_t cmd,
  output hkrt_pkg::sts_t sts
);
  import hkrt_pkg::*;

  // Configuration registers.
  logic       nkro_r;
  logic [7:0] implicit_r;
  logic [7:0] masked_r;
  logic       gui_lock_r;

  // Tracker state.
  logic [7:0] counts_r   [8];
  logic [7:0] counts_nxt [8];
  logic [7:0] held_r, held_nxt;
  logic [7:0] rep_r, rep_nxt;
  logic [7:0] store_r [STORE_DEPTH];

  // Latched item and per-item flags.
  logic [2:0]  action_r;
  logic [7:0]  usage_r;
  logic        changed_r, changed_nxt;
  logic        pressed_r, pressed_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic [READ_W-1:0] read_idx_r;

  // Output stage.
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;
  logic       out_changed_r;
  logic       out_pressed_r;
  logic [1:0] out_status_r;

  // Decode of the latched item.
  logic          is_mod;
  logic          is_key;
  logic [2:0]    mod_idx;
  logic [7:0]    mod_bit;
  logic          above_range;
  logic [7:0]    key_bit;

  // Key store access.
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]          rd_data;
  logic                store_we;
  logic [7:0]          store_wdata;
  logic                store_clr;
  logic                scan_hit;
  logic                scan_end;
  logic [READ_W-1:0]   read_pos;
  logic [7:0]          read_byte;
  logic                out_load;

  assign is_mod = (action_r <= ACT_QUERY) && (usage_r >= MOD_FIRST) && (usage_r <= MOD_LAST);
  assign is_key = (action_r <= ACT_QUERY) && (usage_r != 8'd0) && !is_mod;
  assign mod_idx = usage_r[2:0];
  assign mod_bit = 8'd1 << mod_idx;
  assign key_bit = 8'd1 << usage_r[2:0];
  assign above_range = {1'b0, usage_r} > 9'(NKRO_MAX_USAGE);

  // One read port on the key store, steered by the current phase.
  assign read_pos = read_idx_r - READ_W'(2);
  always_comb begin
    if (cmd.scan_step) begin
      rd_addr = STORE_AW'(slot_r);
    end else if (cmd.read_step) begin
      rd_addr = read_pos[STORE_AW-1:0];
    end else begin
      rd_addr = STORE_AW'(usage_r >> 3);
    end
  end
  assign rd_data = store_r[rd_addr];

  assign scan_hit = (action_r == ACT_PRESS) && (rd_data == 8'd0);
  assign scan_end = (slot_r == SLOT_W'(KEY_SLOTS - 1));

  // Byte selection and end detection of a report read.
  always_comb begin
    if (read_idx_r == READ_W'(0)) begin
      read_byte = rep_r;
    end else if (read_idx_r == READ_W'(1)) begin
      read_byte = {7'd0, nkro_r};
    end else begin
      read_byte = rd_data;
    end
  end

  assign out_load = cmd.emit || cmd.read_step;

  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.is_read     = (action_r == ACT_READ);
  assign sts.is_slot_key = is_key && !nkro_r;
  assign sts.scan_done   = scan_hit || scan_end;
  assign sts.read_last   = nkro_r ? (read_idx_r == READ_W'(READ_LEN_NKRO - 1))
                                  : (read_idx_r == READ_W'(READ_LEN_SLOT - 1));

  // Next values of modifier state, flags and key store writes.
  always_comb begin
    counts_nxt  = counts_r;
    held_nxt    = held_r;
    rep_nxt     = rep_r;
    changed_nxt = changed_r;
    pressed_nxt = pressed_r;
    status_nxt  = status_r;
    store_we    = 1'b0;
    store_wdata = 8'd0;
    store_clr   = 1'b0;

    // Configuration writes; the reported byte follows the mask registers.
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NKRO_MODE:     store_clr = (cfg_data[0] != nkro_r);
        CFG_IMPLICIT_MODS: rep_nxt = compose_mods(held_r, masked_r, cfg_data);
        CFG_MASKED_MODS:   rep_nxt = compose_mods(held_r, cfg_data, implicit_r);
        CFG_GUI_LOCK:      ;
        default:           ;
      endcase
    end

    if (cmd.exec) begin
      changed_nxt = 1'b0;
      pressed_nxt = 1'b0;
      status_nxt  = STS_OK;
      if (action_r == ACT_CLEAR) begin
        store_clr = 1'b1;
        rep_nxt   = 8'd0;
      end else if (is_mod) begin
        case (action_r)
          ACT_PRESS: begin
            if (gui_lock_r && (mod_idx == MOD_LGUI || mod_idx == MOD_RGUI)) begin
              counts_nxt[mod_idx] = 8'd0;
            end else begin
              if (counts_r[mod_idx] != COUNT_MAX) begin
                counts_nxt[mod_idx] = counts_r[mod_idx] + 8'd1;
              end
              held_nxt    = held_r | mod_bit;
              rep_nxt     = compose_mods(held_nxt, masked_r, implicit_r);
              changed_nxt = (rep_nxt != rep_r);
            end
          end
          ACT_RELEASE: begin
            if (counts_r[mod_idx] == 8'd0) begin
              status_nxt = STS_UNDERFLOW;
            end else begin
              counts_nxt[mod_idx] = counts_r[mod_idx] - 8'd1;
              if (counts_r[mod_idx] == 8'd1) begin
                held_nxt = held_r & ~mod_bit;
              end
              rep_nxt     = compose_mods(held_nxt, masked_r, implicit_r);
              changed_nxt = (rep_nxt != rep_r);
            end
          end
          default: begin
            pressed_nxt = held_r[mod_idx];
          end
        endcase
      end else if (is_key && nkro_r) begin
        // Bitmap report: one bit per usage.
        if (above_range) begin
          if (action_r != ACT_QUERY) begin
            status_nxt = STS_RANGE;
          end
        end else begin
          case (action_r)
            ACT_PRESS: begin
              store_we    = 1'b1;
              store_wdata = rd_data | key_bit;
            end
            ACT_RELEASE: begin
              store_we    = 1'b1;
              store_wdata = rd_data & ~key_bit;
            end
            default: begin
              pressed_nxt = |(rd_data & key_bit);
            end
          endcase
        end
      end
    end

    // Slot report: one slot is visited per cycle.
    if (cmd.scan_step) begin
      case (action_r)
        ACT_PRESS: begin
          if (rd_data == 8'd0) begin
            store_we    = 1'b1;
            store_wdata = usage_r;
          end
        end
        ACT_RELEASE: begin
          if (rd_data == usage_r) begin
            store_we    = 1'b1;
            store_wdata = 8'd0;
          end
        end
        default: begin
          if (rd_data == usage_r) begin
            pressed_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nkro_r     <= 1'b0;
      implicit_r <= 8'd0;
      masked_r   <= 8'd0;
      gui_lock_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NKRO_MODE:     nkro_r     <= cfg_data[0];
        CFG_IMPLICIT_MODS: implicit_r <= cfg_data;
        CFG_MASKED_MODS:   masked_r   <= cfg_data;
        CFG_GUI_LOCK:      gui_lock_r <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  // Modifier state and per-item flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        counts_r[i] <= 8'd0;
      end
      held_r    <= 8'd0;
      rep_r     <= 8'd0;
      changed_r <= 1'b0;
      pressed_r <= 1'b0;
      status_r  <= STS_OK;
    end else begin
      counts_r  <= counts_nxt;
      held_r    <= held_nxt;
      rep_r     <= rep_nxt;
      changed_r <= changed_nxt;
      pressed_r <= pressed_nxt;
      status_r  <= status_nxt;
    end
  end

  // Key store: slots or bitmap bytes.
  always_ff @(posedge clk) begin
    if (!rst_n || store_clr) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= 8'd0;
      end
    end else if (store_we) begin
      store_r[rd_addr] <= store_wdata;
    end
  end

  // Latched item.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action_r <= in_action;
      usage_r  <= in_usage;
    end
  end

  // Slot and read counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      read_idx_r <= '0;
    end else begin
      if (cmd.exec) begin
        slot_r <= '0;
      end else if (cmd.scan_step) begin
        slot_r <= slot_r + SLOT_W'(1);
      end
      if (cmd.read_step) begin
        read_idx_r <= sts.read_last ? '0 : read_idx_r + READ_W'(1);
      end
    end
  end

  // Output register; a new result loads only when the old one has left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r    <= rep_r;
      out_last_r    <= 1'b1;
      out_changed_r <= changed_r;
      out_pressed_r <= pressed_r;
      out_status_r  <= status_r;
    end else if (cmd.read_step) begin
      out_data_r    <= read_byte;
      out_last_r    <= sts.read_last;
      out_changed_r <= 1'b0;
      out_pressed_r <= 1'b0;
      out_status_r  <= STS_OK;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_data_r;
  assign out_last         = out_last_r;
  assign out_mods_changed = out_changed_r;
  assign out_pressed      = out_pressed_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  // A load is never issued over a result that is still stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || !out_stall))
    else $error("output register overwritten while stalled");

  // A result that is not the last of its item comes from a report read and has clean flags.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |->
      (!out_changed_r && !out_pressed_r && out_status_r == STS_OK))
    else $error("read byte carries flags");

  // The read counter is back at the start after the last byte of a report.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.read_step && sts.read_last) |=> (read_idx_r == '0))
    else $error("read counter not rewound");
`endif

endmodule

/* sv/hid_keyboard_report_tracker.sv */
// HID keyboard report tracker: a 6KRO slot or NKRO bitmap report with modifier counts.
//
// Usage: items arrive on the in_ channel (in_action, in_usage) with valid/stall
// handshakes; results leave on the out_ channel, one per item, or one per report
// byte for a read. Configuration is written through cfg_we/cfg_index/cfg_data
// while the block is idle.
// Sequencing: an item is taken only when the controller is idle.
// Modifier, bitmap, clear and query items pass from the item latch through the
// execute and emit states to the result register; a slot-mode key item also
// scans up to KEY_SLOTS slots before the emit state, the slot scan reading one
// key store entry per cycle. A report read passes through the execute and read
// states for its bytes (8 in slot mode, 34 in NKRO mode), one byte leaving the
// output register each cycle it is free.
// Reset (rst_n low, synchronous) clears the control registers, counts and the key store.
// When the receiver stalls, the result stays in the output register and the
// controller waits; the next input can still be taken while a final result
// waits to be transferred.
module hid_keyboard_report_tracker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_action,
  input  logic [7:0] in_usage,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data,
  output logic       out_last,
  output logic       out_mods_changed,
  output logic       out_pressed,
  output logic [1:0] out_status
);
  import hkrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  hkrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // State and result path.
  hkrt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_action        (in_action),
    .in_usage         (in_usage),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data),
    .out_last         (out_last),
    .out_mods_changed (out_mods_changed),
    .out_pressed      (out_pressed),
    .out_status       (out_status),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule
